// ----- hdl/binary_min_heap_queue_core_defines.svh -----
// Assertion macros for the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BMHQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, disabled while reset is low.
`define BMHQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

// ----- hdl/bmhq_pkg.sv -----
// Package: sizes, entry type, status codes and controller/datapath interface types.
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 16;
    localparam int OCC_W  = 9;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;
    localparam int M_FIELD_W = KEY_W + PAY_W + OCC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_INS_CHK,
        OP_INS_STEP,
        OP_EXT_READ,
        OP_EXT_LOAD,
        OP_DN_READ,
        OP_DN_STEP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic ins_less;
        logic dn_move;
    } dp_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_EXT_RD,
        ST_EXT_LD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/bmhq_ctrl.sv -----
// Controller: sequences insert sift-up and extract sift-down over the datapath.
`default_nettype none

module bmhq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_mode,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire bmhq_pkg::dp_stat_t stat,
    output bmhq_pkg::ctrl_cmd_t     cmd
);
    import bmhq_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_INSERT) begin
                        state_next = stat.full ? ST_FINISH : ST_INS_CHK;
                    end else begin
                        state_next = stat.empty ? ST_FINISH : ST_EXT_RD;
                    end
                end
            end
            ST_INS_CHK: state_next = stat.pos_zero ? ST_FINISH : ST_INS_CMP;
            ST_INS_CMP: state_next = stat.ins_less ? ST_INS_CHK : ST_FINISH;
            ST_EXT_RD:  state_next = ST_EXT_LD;
            // count is already decremented: a single entry leaves nothing to sift
            ST_EXT_LD:  state_next = stat.empty ? ST_FINISH : ST_DN_RD;
            ST_DN_RD:   state_next = ST_DN_CMP;
            ST_DN_CMP:  state_next = stat.dn_move ? ST_DN_RD : ST_FINISH;
            ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = OP_IDLE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:    cmd.op = accept ? OP_ACCEPT : OP_IDLE;
            ST_INS_CHK: cmd.op = OP_INS_CHK;
            ST_INS_CMP: cmd.op = OP_INS_STEP;
            ST_EXT_RD:  cmd.op = OP_EXT_READ;
            ST_EXT_LD:  cmd.op = OP_EXT_LOAD;
            ST_DN_RD:   cmd.op = OP_DN_READ;
            ST_DN_CMP:  cmd.op = OP_DN_STEP;
            ST_FINISH:  cmd.load_out = out_free;
            default:    cmd.op = OP_IDLE;
        endcase
    end

    assign m_tvalid_next = cmd.load_out || (m_tvalid_reg && !m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- hdl/bmhq_dpath.sv -----
// Datapath: heap storage, hole pointer, carried entry, count and result register.
`default_nettype none

module bmhq_dpath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bmhq_pkg::ctrl_cmd_t          cmd,
    output bmhq_pkg::dp_stat_t                stat,
    input  wire logic                         s_mode,
    input  wire logic [bmhq_pkg::KEY_W-1:0]   s_key,
    input  wire logic [bmhq_pkg::PAY_W-1:0]   s_payload,
    output bmhq_pkg::status_t                 out_status,
    output logic      [bmhq_pkg::KEY_W-1:0]   out_key,
    output logic      [bmhq_pkg::PAY_W-1:0]   out_payload,
    output logic      [bmhq_pkg::OCC_W-1:0]   out_occupancy
);
    import bmhq_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            e_reg, e_next;
    status_t           stat_reg, stat_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PAY_W-1:0]  pay_reg, pay_next;

    status_t           out_stat_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [PAY_W-1:0]  out_pay_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    logic [ADDR_W-1:0]  ra, rb, parent;
    logic [CHILD_W-1:0] lc, rc;
    logic               lc_ok, rc_ok, a_lt, b_lt;
    logic [KEY_W-1:0]   cur_key;
    logic               we;
    entry_t             wd;

    assign parent  = (pos_reg - ADDR_W'(1)) >> 1;
    assign lc      = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign rc      = (CHILD_W'(pos_reg) << 1) + CHILD_W'(2);
    assign lc_ok   = lc < CHILD_W'(count_reg);
    assign rc_ok   = rc < CHILD_W'(count_reg);
    // smaller child wins only on strict less; left child kept on a tie
    assign a_lt    = lc_ok && (rd_a_reg.key < e_reg.key);
    assign cur_key = a_lt ? rd_a_reg.key : e_reg.key;
    assign b_lt    = rc_ok && (rd_b_reg.key < cur_key);

    assign stat.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty    = (count_reg == '0);
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.ins_less = (e_reg.key < rd_a_reg.key);
    assign stat.dn_move  = a_lt || b_lt;

    always_comb begin
        ra = '0;
        rb = '0;
        unique case (cmd.op)
            OP_INS_CHK:  ra = parent;
            OP_EXT_READ: rb = ADDR_W'(count_reg - CNT_W'(1));
            OP_DN_READ: begin
                ra = lc[ADDR_W-1:0];
                rb = rc[ADDR_W-1:0];
            end
            default: ra = '0;
        endcase
    end

    // every write lands on the hole at pos_reg
    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        e_next     = e_reg;
        stat_next  = stat_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        we         = 1'b0;
        wd         = e_reg;
        unique case (cmd.op)
            OP_IDLE: we = 1'b0;
            OP_ACCEPT: begin
                e_next    = '{key: s_key, payload: s_payload};
                key_next  = '0;
                pay_next  = '0;
                stat_next = STAT_OK;
                if (s_mode == MODE_INSERT) begin
                    if (stat.full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        pos_next   = ADDR_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end else if (stat.empty) begin
                    stat_next = STAT_EMPTY;
                end
            end
            OP_INS_CHK: we = stat.pos_zero;
            OP_INS_STEP: begin
                we = 1'b1;
                if (stat.ins_less) begin
                    wd       = rd_a_reg;
                    pos_next = parent;
                end
            end
            OP_EXT_READ: begin
                count_next = count_reg - CNT_W'(1);
            end
            OP_EXT_LOAD: begin
                key_next = rd_a_reg.key;
                pay_next = rd_a_reg.payload;
                e_next   = rd_b_reg;
                pos_next = '0;
            end
            OP_DN_READ: we = 1'b0;
            OP_DN_STEP: begin
                we = 1'b1;
                if (b_lt) begin
                    wd       = rd_b_reg;
                    pos_next = rc[ADDR_W-1:0];
                end else if (a_lt) begin
                    wd       = rd_a_reg;
                    pos_next = lc[ADDR_W-1:0];
                end
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[pos_reg] <= wd;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        e_reg    <= e_next;
        stat_reg <= stat_next;
        key_reg  <= key_next;
        pay_reg  <= pay_next;
        if (cmd.load_out) begin
            out_stat_reg <= stat_reg;
            out_key_reg  <= key_reg;
            out_pay_reg  <= pay_reg;
            out_occ_reg  <= OCC_W'(count_reg);
        end
    end

    assign out_status    = out_stat_reg;
    assign out_key       = out_key_reg;
    assign out_payload   = out_pay_reg;
    assign out_occupancy = out_occ_reg;

endmodule

`default_nettype wire

// ----- hdl/binary_min_heap_queue_core.sv -----
// Top level: binary min-heap priority queue with stream input and result channels.
//
// Input channel s_*: one item per operation. s_tuser is the mode (0 insert,
// 1 extract minimum); s_tdata carries the key and payload of an insert.
// Result channel m_*: exactly one item per input item, in order. m_tuser is
// the status (0 ok, 1 full and insert dropped, 2 empty); m_tdata carries
// the extracted key and payload (zero otherwise) and the occupancy after it.
// Items are worked one at a time. s_tready is high while the controller idles.
// A dropped insert or an empty extract goes straight to the result. An
// insert climbs from the new leaf towards the root; an extract moves the
// last entry to the root and lets it sink. Each level costs one read of
// the heap memory (two ports, registered read data) and a compare-and-write step.
// A finished result waits in the output register; the next item is taken
// while it waits, and that item only holds in its last cycle if the earlier
// result has still not been taken by the receiver.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; the heap memory needs no clearing, entries past the count are unused.
`default_nettype none

module binary_min_heap_queue_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [31:0] entry_key, [47:32] entry_payload
    input  wire logic [bmhq_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] mode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] out_key, [47:32] out_payload, [56:48] occupancy, [63:57] zero
    output logic      [bmhq_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic      [bmhq_pkg::STAT_W-1:0]        m_tuser
);
    import bmhq_pkg::*;

    ctrl_cmd_t        cmd;
    dp_stat_t         stat;
    status_t          out_status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [OCC_W-1:0] out_occupancy;

    bmhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmhq_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_mode        (s_tuser),
        .s_key         (s_tdata[KEY_W-1:0]),
        .s_payload     (s_tdata[KEY_W+PAY_W-1:KEY_W]),
        .out_status    (out_status),
        .out_key       (out_key),
        .out_payload   (out_payload),
        .out_occupancy (out_occupancy)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_occupancy, out_payload, out_key};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

// ----- hdl/bmhq_checker.sv -----
// Port-level checker for the heap queue core, bound to the top level.
`default_nettype none
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [bmhq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [bmhq_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [bmhq_pkg::STAT_W-1:0]    m_tuser
);
    import bmhq_pkg::*;

    logic s_take;
    logic m_wait;
    logic [KEY_W+PAY_W-1:0] m_entry;
    logic [OCC_W-1:0]       m_occ;

    assign s_take  = s_tvalid && s_tready;
    assign m_wait  = m_tvalid && !m_tready;
    assign m_entry = m_tdata[KEY_W+PAY_W-1:0];
    assign m_occ   = m_tdata[M_FIELD_W-1:KEY_W+PAY_W];

    `BMHQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_wait, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // one item in flight: the input closes right after a take
    `BMHQ_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_take, !s_tready)
    `BMHQ_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser != STAT_OK), m_entry == '0)
    `BMHQ_ASSERT_NOW(a_empty_occ, aclk, aresetn, m_tvalid && (m_tuser == STAT_EMPTY), m_occ == '0)

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
